@@ hw/rtl/strf_pkg.sv @@
package strf_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TS_W        = 63;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = ((IDX_W + 2 * TS_W) + 7) / 8 * 8;
  localparam int M_DATA_W = ((2 + IDX_W + TS_W) + 7) / 8 * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 1'b1;

  // Request kinds carried on s_tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_LO,
    ST_HI,
    ST_OUT
  } strf_state_t;

  // Table write request.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [TS_W-1:0]  data;
  } strf_wr_t;

  // Table read request.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } strf_rd_t;

endpackage

@@ hw/rtl/sorted_timestamp_record_filter_core.sv @@
// Sorted timestamp record filter. A load beat (s_tuser low) writes one
// timestamp into the 1024-entry table and resets the search hint; it
// returns no result. A query beat (s_tuser high) runs a binary search from
// the hint up to the last valid entry and returns one result beat with
// found, keep, the final lower bound and the timestamp. The table sits in a
// synchronous memory with one write and one registered read port, and the
// search waits on each read: it accepts the query, runs about
// log2(table_count) halving steps, reads both final bounds and posts the
// result; an empty table skips the search. Entries must be loaded before
// they are searched; the user must write table_count and keep_mode only
// while the block is idle, as the block itself does not enforce it.
module sorted_timestamp_record_filter_core (
  input  logic                               clk,
  input  logic                               rst,
  // fields from bit 0: entry_index, entry_value, record_timestamp
  input  logic [strf_pkg::S_DATA_W-1:0]      s_tdata,
  // fields from bit 0: req_type
  input  logic                               s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // fields from bit 0: keep, found, search_position, record_timestamp_out
  output logic [strf_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [strf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [strf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import strf_pkg::*;

  strf_state_t      state, state_next;
  logic             keep_mode;
  logic [CNT_W-1:0] table_count;
  logic [IDX_W-1:0] hint;
  logic [IDX_W-1:0] lo, lo_next;
  logic [IDX_W-1:0] hi, hi_next;
  logic [IDX_W-1:0] mid, mid_next;
  logic [TS_W-1:0]  key;
  logic             hit_lo, hit_lo_next;
  logic             found, found_next;
  logic             out_load;
  logic             hint_load;

  strf_wr_t         wr;
  strf_rd_t         rd;
  logic [TS_W-1:0]  rdata;

  logic [CNT_W-1:0] count_sat;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] lo_start;
  logic [IDX_W-1:0] lo_sel, hi_sel;
  logic [CNT_W-1:0] bound_sum;
  logic             narrow;

  logic             accept;
  logic [IDX_W-1:0] in_index;
  logic [TS_W-1:0]  in_value;
  logic [TS_W-1:0]  in_key;

  assign accept   = s_tvalid && s_tready;
  assign in_index = s_tdata[IDX_W-1:0];
  assign in_value = s_tdata[IDX_W+TS_W-1:IDX_W];
  assign in_key   = s_tdata[IDX_W+2*TS_W-1:IDX_W+TS_W];

  // Table memory.
  strf_table u_table (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mode   <= 1'b1;
      table_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEP_MODE:   keep_mode   <= cfg_data[0];
        CFG_TABLE_COUNT: table_count <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Valid entry count, saturated to the table depth, and the search start.
  always_comb begin
    count_sat = (table_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_count;
    last      = IDX_W'(count_sat - CNT_W'(1));
    lo_start  = (hint > last) ? last : hint;
  end

  // Bounds for the next step: start values on a new query, otherwise the
  // bounds narrowed by the entry just read at mid.
  always_comb begin
    lo_sel = lo;
    hi_sel = hi;
    if (state == ST_IDLE) begin
      lo_sel = lo_start;
      hi_sel = last;
    end else if (state == ST_MID) begin
      if (rdata == key) begin
        lo_sel = mid;
        hi_sel = mid;
      end else if (key < rdata) begin
        hi_sel = mid;
      end else begin
        lo_sel = mid;
      end
    end
    bound_sum = {1'b0, lo_sel} + {1'b0, hi_sel};
    narrow    = ({1'b0, lo_sel} + CNT_W'(1)) >= {1'b0, hi_sel};
  end

  // Sequencer: next state, memory requests and result capture.
  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    hit_lo_next = hit_lo;
    found_next  = found;
    out_load    = 1'b0;
    hint_load   = 1'b0;
    s_tready    = (state == ST_IDLE);
    wr.en       = 1'b0;
    wr.addr     = in_index;
    wr.data     = in_value;
    rd.en       = 1'b0;
    rd.addr     = lo_sel;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_LOAD) begin
            wr.en = 1'b1;
          end else if (count_sat == '0) begin
            lo_next    = hint;
            found_next = 1'b0;
            state_next = ST_OUT;
          end else begin
            lo_next = lo_sel;
            hi_next = hi_sel;
            rd.en   = 1'b1;
            if (narrow) begin
              rd.addr    = lo_sel;
              state_next = ST_LO;
            end else begin
              mid_next   = bound_sum[CNT_W-1:1];
              rd.addr    = bound_sum[CNT_W-1:1];
              state_next = ST_MID;
            end
          end
        end
      end
      ST_MID: begin
        lo_next = lo_sel;
        hi_next = hi_sel;
        rd.en   = 1'b1;
        if (narrow) begin
          rd.addr    = lo_sel;
          state_next = ST_LO;
        end else begin
          mid_next = bound_sum[CNT_W-1:1];
          rd.addr  = bound_sum[CNT_W-1:1];
        end
      end
      ST_LO: begin
        hit_lo_next = (rdata == key);
        rd.en       = 1'b1;
        rd.addr     = hi;
        state_next  = ST_HI;
      end
      ST_HI: begin
        found_next = hit_lo || (rdata == key);
        hint_load  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hint  <= '0;
    end else begin
      state <= state_next;
      if (accept && s_tuser == REQ_LOAD) begin
        hint <= '0;
      end else if (hint_load) begin
        hint <= lo;
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    hit_lo <= hit_lo_next;
    found  <= found_next;
    if (accept && s_tuser == REQ_QUERY) begin
      key <= in_key;
    end
  end

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= M_DATA_W'({key, lo, found, found ? keep_mode : !keep_mode});
    end
  end

endmodule

@@ hw/rtl/strf_table.sv @@
module strf_table (
  input  logic                       clk,
  input  strf_pkg::strf_wr_t         wr,
  input  strf_pkg::strf_rd_t         rd,
  output logic [strf_pkg::TS_W-1:0]  rdata
);
  import strf_pkg::*;

  logic [TS_W-1:0] mem [TABLE_DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

@@ hw/rtl/strf_checker.sv @@
module strf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tuser,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [strf_pkg::M_DATA_W-1:0]    m_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready
);
  import strf_pkg::*;

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A query occupies the block: no new beat is taken in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_QUERY |=> !s_tready)
    else $error("input taken right after a query");

  // A load produces no result beat.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_LOAD && !m_tvalid |=> !m_tvalid)
    else $error("result beat after a load");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // Padding bits of the result beat stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_DATA_W-1:2+IDX_W+TS_W] == '0)
    else $error("nonzero padding in result beat");

endmodule

bind sorted_timestamp_record_filter_core strf_checker u_strf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tuser  (s_tuser),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ sim/tb_sorted_timestamp_record_filter_core.sv @@
`timescale 1ns / 100ps

module tb_sorted_timestamp_record_filter_core;
  import strf_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 600000;
  // Loads give no result, so wait past the longest search.
  localparam int IDLE_PAUSE  = 24;

  // Bit positions inside the stream payloads.
  localparam int VAL_LSB = IDX_W;
  localparam int KEY_LSB = IDX_W + TS_W;
  localparam int POS_LSB = 2;
  localparam int OTS_LSB = 2 + IDX_W;

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  val;
    logic [TS_W-1:0]  key;
  } filter_req_t;

  typedef struct {
    logic             keep;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [TS_W-1:0]  key;
  } filter_decision_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  sorted_timestamp_record_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: table contents, search hint and registers.
  logic [TS_W-1:0]   search_table [TABLE_DEPTH];
  logic [IDX_W-1:0]  search_hint  = '0;
  logic              keep_mode_q  = 1'b1;
  logic [CNT_W-1:0]  table_count_q = '0;

  filter_req_t      pending_beats [$];
  filter_decision_t pending_decisions [$];

  // Values the stimulus believes are loaded, used to aim queries at hits.
  logic [TS_W-1:0] loaded_vals [TABLE_DEPTH];
  int              value_spread = 0;
  // Entries on the outermost search paths of a full-depth table.
  int              deep_nodes [$];

  bit in_took    = 1'b0;
  bit out_took   = 1'b0;
  bit in_burst   = 1'b0;
  bit out_burst  = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  int cycles     = 0;
  int errors     = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Binary search from the hint up to the last valid entry.
  task automatic predict_query(input logic [TS_W-1:0] key);
    int unsigned n, lo, hi, mid;
    bit hit;
    filter_decision_t d;
    n   = (table_count_q > TABLE_DEPTH) ? TABLE_DEPTH : table_count_q;
    lo  = search_hint;
    hit = 1'b0;
    if (n > 0) begin
      hi = n - 1;
      if (lo > hi) lo = hi;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (key == search_table[mid]) begin
          lo = mid;
          hi = mid;
        end else if (key < search_table[mid]) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
      hit = (search_table[lo] == key) || (search_table[hi] == key);
      search_hint = lo[IDX_W-1:0];
    end
    d.keep  = hit ? keep_mode_q : ~keep_mode_q;
    d.found = hit;
    d.pos   = lo[IDX_W-1:0];
    d.key   = key;
    pending_decisions.push_back(d);
  endtask

  // Monitor: predict on each accepted request beat, check each result beat.
  always @(posedge clk) begin
    cycles   <= cycles + 1;
    in_took  <= s_tvalid && s_tready;
    out_took <= m_tvalid && m_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_LOAD) begin
          search_table[s_tdata[IDX_W-1:0]] = s_tdata[VAL_LSB +: TS_W];
          search_hint = '0;
        end else begin
          predict_query(s_tdata[KEY_LSB +: TS_W]);
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_decisions.size() == 0) begin
          report($sformatf("result beat with none expected, data %h", m_tdata));
        end else begin
          filter_decision_t w;
          w = pending_decisions.pop_front();
          if (m_tdata[0] !== w.keep || m_tdata[1] !== w.found ||
              m_tdata[POS_LSB +: IDX_W] !== w.pos || m_tdata[OTS_LSB +: TS_W] !== w.key)
            report($sformatf("keep %b/%b found %b/%b pos %0d/%0d ts %h/%h (got/want)",
                             m_tdata[0], w.keep, m_tdata[1], w.found,
                             m_tdata[POS_LSB +: IDX_W], w.pos,
                             m_tdata[OTS_LSB +: TS_W], w.key));
        end
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Request driver: a random gap before each beat, beat held until taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        filter_req_t b;
        b = pending_beats.pop_front();
        s_tdata  <= {b.key, b.val, b.idx};
        s_tuser  <= b.kind;
        s_tvalid <= 1'b1;
        gap_left = in_burst ? 0 : $urandom_range(0, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: a random stall after each taken result beat.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_took) stall_left = out_burst ? 0 : $urandom_range(0, 11);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_load(input int idx, input logic [TS_W-1:0] val);
    filter_req_t b;
    b.kind = REQ_LOAD;
    b.idx  = idx[IDX_W-1:0];
    b.val  = val;
    b.key  = TS_W'({$urandom, $urandom});
    loaded_vals[idx] = val;
    pending_beats.push_back(b);
  endtask

  task automatic queue_query(input logic [TS_W-1:0] key);
    filter_req_t b;
    b.kind = REQ_QUERY;
    b.idx  = IDX_W'($urandom);
    b.val  = TS_W'({$urandom, $urandom});
    b.key  = key;
    pending_beats.push_back(b);
  endtask

  // Block until every beat is taken and every result has come back.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || s_tvalid || pending_decisions.size() != 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEEP_MODE) keep_mode_q = data[0];
    else table_count_q = data[CNT_W-1:0];
  endtask

  function automatic logic [TS_W-1:0] draw_value();
    case (value_spread)
      0:       draw_value = TS_W'({$urandom, $urandom});
      1:       draw_value = TS_W'($urandom_range(0, 40));
      default: draw_value = TS_MAX - TS_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Ascending by index: the index sits above the random low bits.
  function automatic logic [TS_W-1:0] deep_value(input int k);
    return (TS_W'(k) << 52) | TS_W'($urandom);
  endfunction

  // Fill entries 0..n-1 with sorted random values, in random load order.
  task automatic load_table(input int n);
    logic [TS_W-1:0] vals [$];
    int order [$];
    value_spread = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      vals.push_back(draw_value());
      order.push_back(k);
    end
    vals.sort();
    order.shuffle();
    foreach (order[k]) queue_load(order[k], vals[order[k]]);
  endtask

  // Load only the entries that the deep searches below can reach.
  task automatic load_deep_nodes();
    deep_nodes = '{0, 1, 2, 3, 7, 15, 31, 63, 127, 255, 511, 767, 895, 959, 991,
                   1007, 1015, 1019, 1021, 1022, 1023};
    foreach (deep_nodes[k]) queue_load(deep_nodes[k], deep_value(deep_nodes[k]));
    // Entry 4 is read only once the count drops to five.
    queue_load(4, deep_value(4));
  endtask

  // Searches from a zero hint that end on a loaded entry, then the two extremes.
  task automatic deep_phase(input int cnt, input int n_query);
    wait_idle();
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    write_reg(CFG_KEEP_MODE, $urandom_range(0, 1));
    write_reg(CFG_TABLE_COUNT, cnt);
    for (int q = 0; q < n_query; q++) begin
      // Rewriting entry 0 with its own value only resets the hint.
      queue_load(0, loaded_vals[0]);
      queue_query(loaded_vals[deep_nodes[$urandom_range(0, deep_nodes.size() - 1)]]);
    end
    queue_load(0, loaded_vals[0]);
    queue_query('0);
    queue_query(TS_MAX);
    queue_query(TS_MAX);
    queue_query('0);
  endtask

  // Program the registers while idle, then run a batch of queries.
  task automatic query_phase(input int cnt, input bit mode, input int n_query);
    int n, pick, r;
    logic [TS_W-1:0] key;
    n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    wait_idle();
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    write_reg(CFG_KEEP_MODE, mode);
    write_reg(CFG_TABLE_COUNT, cnt);
    for (int q = 0; q < n_query; q++) begin
      r    = $urandom_range(0, 99);
      pick = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (n > 0 && r < 8) begin
        // Rewrite an entry: same value keeps order, only the hint resets.
        queue_load(pick, loaded_vals[pick]);
      end else if (n > 0 && r < 11) begin
        queue_load(pick, draw_value());
      end
      if (n > 0 && r < 60) key = loaded_vals[pick];
      else if (n > 0 && r < 75)
        key = (r & 1) ? loaded_vals[pick] + TS_W'(1) : loaded_vals[pick] - TS_W'(1);
      else if (r < 80) key = (r & 1) ? TS_MAX : '0;
      else key = draw_value();
      queue_query(key);
    end
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table straight out of reset.
    queue_query('0);
    queue_query(TS_MAX);
    // Eight sorted entries spanning the full value range.
    queue_load(0, 0);
    queue_load(1, 5);
    queue_load(2, 10);
    queue_load(3, 20);
    queue_load(4, 40);
    queue_load(5, 80);
    queue_load(6, 63'h4000_0000_0000_0000);
    queue_load(7, TS_MAX);
    wait_idle();
    write_reg(CFG_KEEP_MODE, 1);
    write_reg(CFG_TABLE_COUNT, 8);
    queue_query(0);
    queue_query(TS_MAX);
    queue_query(20);
    queue_query(21);
    // Key below where the hint now starts the search.
    queue_query(5);
    queue_query(TS_MAX);
    // Shrink the table so the hint lies beyond the last entry.
    wait_idle();
    write_reg(CFG_KEEP_MODE, 0);
    write_reg(CFG_TABLE_COUNT, 3);
    queue_query(10);
    queue_query(3);
    wait_idle();
    write_reg(CFG_TABLE_COUNT, 1);
    queue_query(0);
    queue_query(1);
    wait_idle();
    write_reg(CFG_TABLE_COUNT, 2);
    queue_query(5);
    queue_load(1, 5);
    queue_query(5);

    // Deep searches at full depth, then counts above the table depth.
    load_deep_nodes();
    deep_phase(TABLE_DEPTH, 20);
    deep_phase(2047, 10);
    deep_phase(1500, 10);
    // Small count right after deep searches leaves the hint past the end.
    query_phase(5, $urandom_range(0, 1), 15);

    // Mostly small tables with random content and settings.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       n = 0;
        1:       n = 1;
        2:       n = 2;
        3:       n = 3;
        default: n = $urandom_range(4, 32);
      endcase
      load_table(n);
      query_phase(n, $urandom_range(0, 1), $urandom_range(12, 20));
    end

    wait_idle();
    if (pending_decisions.size() != 0)
      report($sformatf("%0d results never arrived", pending_decisions.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
